// File: rtl/core/xvbc_pkg.sv
`default_nettype none

package xvbc_pkg;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;

  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_WORD3_LOW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DECRYPT_MODE  = 3'd4;

  typedef struct packed {
    logic [7:0]  ctr;
    logic [31:0] z;
    logic [31:0] y;
  } xvbc_item_t;

  typedef struct packed {
    logic        decrypt;
    logic [23:0] k3_low;
    logic [31:0] k2;
    logic [31:0] k1;
    logic [31:0] k0;
  } xvbc_key_t;

  function automatic logic [31:0] rotl32(input logic [31:0] w, input logic [4:0] s);
    logic [63:0] d;
    d = {w, w} << s;
    return d[63:32];
  endfunction

  function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] sum,
                                      input logic [31:0] kw);
    logic [31:0] a;
    a = ((x << 4) ^ (x >> 5)) + (x ^ sum);
    return a + rotl32(kw, x[4:0]);
  endfunction

  function automatic logic [31:0] key_sel(input logic [1:0] idx, input xvbc_key_t key,
                                          input logic [7:0] ctr);
    logic [31:0] k;
    case (idx)
      2'd0:    k = key.k0;
      2'd1:    k = key.k1;
      2'd2:    k = key.k2;
      default: k = {ctr, key.k3_low};
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/xtea_variant_block_cipher.sv
`default_nettype none

// Modified XTEA engine for 64-bit blocks. A front stage takes a block, picks
// its block counter value (0 when in_tuser marks the first block of a
// message, else the running counter, wrapping at 256) and writes it into a
// two-entry queue. The round unit pulls one block at a time and runs one full
// round per cycle: a pre-whitening step, NUM_ROUNDS rounds, then a
// post-whitening step into the output register, which waits while the output
// register is still held. Key registers and decrypt_mode must be written
// through cfg_* only while no block is in flight; the block does not enforce
// this. The top byte of key word 3 is always the block counter.
module xtea_variant_block_cipher
  import xvbc_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [63:0]          in_tdata,   // block_low, block_high
  input  wire logic                 in_tuser,   // first_block
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [63:0]               out_tdata   // result_low, result_high
);

  xvbc_key_t  key_r, key_nxt;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_not_empty;
  xvbc_item_t push_item;
  xvbc_item_t pop_item;

  always_comb begin
    key_nxt = key_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_WORD0:     key_nxt.k0      = cfg_data;
        CFG_KEY_WORD1:     key_nxt.k1      = cfg_data;
        CFG_KEY_WORD2:     key_nxt.k2      = cfg_data;
        CFG_KEY_WORD3_LOW: key_nxt.k3_low  = cfg_data[23:0];
        CFG_DECRYPT_MODE:  key_nxt.decrypt = cfg_data[0];
        default:           key_nxt = key_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  xvbc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  xvbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  xvbc_back #(
    .NUM_ROUNDS (NUM_ROUNDS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .key         (key_r),
    .q_not_empty (q_not_empty),
    .q_item      (pop_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

endmodule

`default_nettype wire

// File: rtl/core/xvbc_queue.sv
`default_nettype none

module xvbc_queue
  import xvbc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire xvbc_item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output xvbc_item_t      pop_item
);

  xvbc_item_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full      = (count_r == 2'd2);
  assign not_empty = (count_r != 2'd0);
  assign pop_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = ~wr_ptr_r;
    end
    if (pop) begin
      rd_ptr_nxt = ~rd_ptr_r;
    end
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/xvbc_front.sv
`default_nettype none

module xvbc_front
  import xvbc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  input  wire logic        in_tuser,
  input  wire logic        q_full,
  output logic             q_push,
  output xvbc_item_t       q_item
);

  logic [7:0] cnt_r, cnt_nxt;
  logic [7:0] ctr_used;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;
  assign ctr_used  = in_tuser ? 8'd0 : cnt_r;

  assign q_item.y   = in_tdata[31:0];
  assign q_item.z   = in_tdata[63:32];
  assign q_item.ctr = ctr_used;

  // advance the block counter past the value this block uses
  assign cnt_nxt = q_push ? (ctr_used + 8'd1) : cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 8'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/xvbc_back.sv
`default_nettype none

module xvbc_back
  import xvbc_pkg::*;
#(
  parameter int unsigned NUM_ROUNDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire xvbc_key_t   key,
  input  wire logic        q_not_empty,
  input  wire xvbc_item_t  q_item,
  output logic             q_pop,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [63:0]      out_tdata
);

  localparam int unsigned RW = (NUM_ROUNDS > 1) ? $clog2(NUM_ROUNDS) : 1;
  localparam logic [63:0] SUM_DEC_W = 64'(DELTA) * 64'(NUM_ROUNDS);
  localparam logic [31:0] SUM_DEC   = SUM_DEC_W[31:0];
  localparam logic [RW-1:0] LAST_RND = RW'(NUM_ROUNDS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [RW-1:0] rnd_r, rnd_nxt;
  logic [31:0]   y_r, y_nxt;
  logic [31:0]   z_r, z_nxt;
  logic [31:0]   sum_r, sum_nxt;
  logic [7:0]    ctr_r, ctr_nxt;
  logic          dec_r, dec_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [63:0]   out_data_r, out_data_nxt;

  logic [31:0]   enc_y, enc_z, enc_sum;
  logic [31:0]   dec_y, dec_z, dec_sum;
  logic [31:0]   k3;
  logic          out_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_free   = !out_valid_r || out_tready;
  assign q_pop      = (state_r == S_IDLE) && q_not_empty;
  assign k3         = {ctr_r, key.k3_low};

  always_comb begin
    enc_y   = y_r + mix(z_r, sum_r, key_sel(sum_r[1:0], key, ctr_r));
    enc_sum = sum_r + DELTA;
    enc_z   = z_r + mix(enc_y, enc_sum, key_sel(enc_sum[12:11], key, ctr_r));
    dec_z   = z_r - mix(y_r, sum_r, key_sel(sum_r[12:11], key, ctr_r));
    dec_sum = sum_r - DELTA;
    dec_y   = y_r - mix(dec_z, dec_sum, key_sel(dec_sum[1:0], key, ctr_r));
  end

  always_comb begin
    state_nxt     = state_r;
    rnd_nxt       = rnd_r;
    y_nxt         = y_r;
    z_nxt         = z_r;
    sum_nxt       = sum_r;
    ctr_nxt       = ctr_r;
    dec_nxt       = dec_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_IDLE: begin
        if (q_not_empty) begin
          ctr_nxt   = q_item.ctr;
          dec_nxt   = key.decrypt;
          rnd_nxt   = '0;
          state_nxt = S_RUN;
          if (key.decrypt) begin
            y_nxt   = q_item.y ^ key.k2;
            z_nxt   = q_item.z ^ {q_item.ctr, key.k3_low};
            sum_nxt = SUM_DEC;
          end else begin
            y_nxt   = q_item.y + key.k0;
            z_nxt   = q_item.z + key.k1;
            sum_nxt = 32'd0;
          end
        end
      end
      S_RUN: begin
        if (dec_r) begin
          y_nxt   = dec_y;
          z_nxt   = dec_z;
          sum_nxt = dec_sum;
        end else begin
          y_nxt   = enc_y;
          z_nxt   = enc_z;
          sum_nxt = enc_sum;
        end
        rnd_nxt = rnd_r + 1'b1;
        if (rnd_r == LAST_RND) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (dec_r) begin
            out_data_nxt = {z_r - key.k1, y_r - key.k0};
          end else begin
            out_data_nxt = {z_r ^ k3, y_r ^ key.k2};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rnd_r      <= rnd_nxt;
    y_r        <= y_nxt;
    z_r        <= z_nxt;
    sum_r      <= sum_nxt;
    ctr_r      <= ctr_nxt;
    dec_r      <= dec_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

// File: bench/tb_top.sv
module tb_top
  import xvbc_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROUNDS = 32;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned BLOCKS_PER_PHASE = 105;
  localparam int unsigned RX_HOLD_CYCLES = 400;

  typedef struct {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        first;
  } block_row_t;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata = '0;   // block_low, block_high
  logic                 in_tuser = 1'b0; // first_block
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;       // result_low, result_high

  logic [31:0] key_w0, key_w1, key_w2;
  logic [23:0] key_w3_low;
  logic        decrypting;
  logic [7:0]  msg_block_ctr;

  logic [63:0] cipher_q[$];
  logic [63:0] want;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_hold_left = 0;
  logic        rx_hold_req = 1'b0;

  block_row_t corner_rows[8] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1},
    '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0},
    '{32'h0000_0000, 32'hFFFF_FFFF, 1'b0},
    '{32'hFFFF_FFFF, 32'h0000_0000, 1'b0},
    '{32'h0000_0001, 32'h8000_0000, 1'b0},
    '{32'h0000_0000, 32'h0000_0000, 1'b0},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0}
  };

  xtea_variant_block_cipher #(
    .NUM_ROUNDS(ROUNDS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] w, input logic [4:0] amt);
    if (amt == 5'd0) return w;
    return (w << amt) | (w >> (6'd32 - {1'b0, amt}));
  endfunction

  function automatic logic [31:0] round_mix(input logic [31:0] x, input logic [31:0] s,
                                            input logic [31:0] k);
    return (((x << 4) ^ (x >> 5)) + (x ^ s)) + rot_left(k, x[4:0]);
  endfunction

  function automatic logic [63:0] cipher_block(input logic [31:0] lo, input logic [31:0] hi,
                                               input logic [7:0] ctr);
    logic [31:0] y, z, s;
    logic [31:0] kw[4];
    kw[0] = key_w0;
    kw[1] = key_w1;
    kw[2] = key_w2;
    kw[3] = {ctr, key_w3_low};
    y = lo;
    z = hi;
    if (!decrypting) begin
      s = 32'd0;
      y = y + kw[0];
      z = z + kw[1];
      for (int r = 0; r < ROUNDS; r++) begin
        y = y + round_mix(z, s, kw[s[1:0]]);
        s = s + DELTA;
        z = z + round_mix(y, s, kw[s[12:11]]);
      end
      y = y ^ kw[2];
      z = z ^ kw[3];
    end else begin
      s = DELTA * ROUNDS;
      z = z ^ kw[3];
      y = y ^ kw[2];
      for (int r = 0; r < ROUNDS; r++) begin
        z = z - round_mix(y, s, kw[s[12:11]]);
        s = s - DELTA;
        y = y - round_mix(z, s, kw[s[1:0]]);
      end
      z = z - kw[1];
      y = y - kw[0];
    end
    return {z, y};
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h1 << $urandom_range(31);
      3:       return ~(32'h1 << $urandom_range(31));
      default: return $urandom;
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1, input logic [31:0] k2,
                          input logic [23:0] k3l, input logic dec);
    write_reg(CFG_KEY_WORD0, k0);
    write_reg(CFG_KEY_WORD1, k1);
    write_reg(CFG_KEY_WORD2, k2);
    write_reg(CFG_KEY_WORD3_LOW, {8'h00, k3l});
    write_reg(CFG_DECRYPT_MODE, {31'd0, dec});
    cfg_we <= 1'b0;
    key_w0 = k0;
    key_w1 = k1;
    key_w2 = k2;
    key_w3_low = k3l;
    decrypting = dec;
  endtask

  task automatic push_block(input logic [31:0] lo, input logic [31:0] hi, input logic first);
    logic [7:0] ctr;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {hi, lo};
    in_tuser <= first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    ctr = first ? 8'd0 : msg_block_ctr;
    cipher_q.push_back(cipher_block(lo, hi, ctr));
    msg_block_ctr = ctr + 8'd1;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (cipher_q.size() != 0);
  endtask

  task automatic flag_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %08h got %08h", what, exp_v, got_v);
  endtask

  // hold off out_tready for a long stretch when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left = RX_HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (cipher_q.size() == 0) begin
        flag_mismatch("unexpected transfer", 32'h0, out_tdata[31:0]);
      end else begin
        want = cipher_q.pop_front();
        if (out_tdata[31:0] !== want[31:0])
          flag_mismatch("result_low", want[31:0], out_tdata[31:0]);
        if (out_tdata[63:32] !== want[63:32])
          flag_mismatch("result_high", want[63:32], out_tdata[63:32]);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    logic [31:0] k3_word;
    logic        first;
    key_w0 = '0;
    key_w1 = '0;
    key_w2 = '0;
    key_w3_low = '0;
    decrypting = 1'b0;
    msg_block_ctr = '0;
    tx_idle_pct = 10;
    rx_idle_pct = 69;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int set_i = 0; set_i < 3; set_i++) begin
      if (set_i == 1) load_key('1, '1, '1, '1, 1'b1);
      if (set_i == 2) load_key('1, '1, '1, '1, 1'b0);
      foreach (corner_rows[i])
        push_block(corner_rows[i].lo, corner_rows[i].hi, corner_rows[i].first);
      drain_results();
    end

    for (int p = 0; p < 6; p++) begin
      k3_word = rand_word();
      load_key(rand_word(), rand_word(), rand_word(), k3_word[23:0], 1'($urandom_range(1)));
      if (p < 2) begin
        tx_idle_pct = 10;
        rx_idle_pct = 69;
      end else if (p < 4) begin
        tx_idle_pct = 69;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (p == 0) rx_hold_req = 1'b1;
      for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
        if (p == 3 && n == 50) drain_results();
        // phases 1..3 never start a message, so the block counter wraps
        first = (p >= 1 && p <= 3) ? 1'b0 : ($urandom_range(15) == 0);
        push_block(rand_word(), rand_word(), first);
      end
      drain_results();
    end

    repeat (60) @(posedge clk);
    if (mismatch_count == 0 && cipher_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
